@@ design/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PSC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/psc_pkg.sv @@
// Package: constants, codes and types of the postfix stack calculator.
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DIV_CNT_W   = $clog2(DATA_WIDTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_REM  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_PUSH,
        KIND_ADD,
        KIND_SUB,
        KIND_MUL,
        KIND_REM,
        KIND_NOP
    } kind_t;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_DIV_ZERO  = 2'd2,
        STAT_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CORE_IDLE,
        CORE_READ,
        CORE_DIV,
        CORE_DROP,
        CORE_RESP
    } core_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        kind_t                   kind;
        logic [DATA_WIDTH-1:0]   value;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } qlink_t;

endpackage

`default_nettype wire

@@ design/psc_div.sv @@
// Iterative signed remainder unit, one quotient bit per cycle, C truncation.
`timescale 1ns / 1ps
`default_nettype none

module psc_div
    import psc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      remainder
);

    div_state_t              state_reg, state_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0]   dvd_reg, dvd_next;
    logic [DATA_WIDTH-1:0]   dvs_reg, dvs_next;
    logic [DATA_WIDTH-1:0]   rem_reg, rem_next;
    logic                    neg_reg, neg_next;
    logic [DATA_WIDTH:0]     shifted;
    logic [DATA_WIDTH:0]     diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign shifted   = {rem_reg, dvd_reg[DATA_WIDTH-1]};
    assign diff      = shifted - {1'b0, dvs_reg};
    assign remainder = neg_reg ? (DATA_WIDTH'(0) - rem_reg) : rem_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        done       = 1'b0;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    neg_next   = dividend[DATA_WIDTH-1];
                    dvd_next   = dividend[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - dividend)
                                                        : dividend;
                    dvs_next   = divisor[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - divisor)
                                                       : divisor;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                rem_next = diff[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
                dvd_next = {dvd_reg[DATA_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DATA_WIDTH - 1))
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                done       = 1'b1;
                state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/psc_front.sv @@
// Front end: takes command words, decodes them and queues them for the core.
`timescale 1ns / 1ps
`default_nettype none

module psc_front
    import psc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_stall,
    input  wire logic [2:0]            cmd,
    input  wire logic [31:0]           operand_value,
    output qlink_t                     q_out,
    input  wire logic                  q_pop
);

    op_t                 q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                push;
    logic                pop;
    op_t                 dec;

    always_comb
    begin
        dec.value = operand_value;
        unique case (cmd)
            CMD_PUSH: dec.kind = KIND_PUSH;
            CMD_ADD:  dec.kind = KIND_ADD;
            CMD_SUB:  dec.kind = KIND_SUB;
            CMD_MUL:  dec.kind = KIND_MUL;
            CMD_REM:  dec.kind = KIND_REM;
            default:  dec.kind = KIND_NOP;
        endcase
    end

    assign cmd_stall   = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign push        = cmd_valid && !cmd_stall;
    assign pop         = q_pop && (cnt_reg != '0);
    assign q_out.valid = (cnt_reg != '0);
    assign q_out.op    = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

@@ design/psc_core.sv @@
// Back end: stack memory, top-of-stack register, ALU and result register.
`timescale 1ns / 1ps
`default_nettype none

module psc_core
    import psc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire qlink_t                q_in,
    output logic                       q_pop,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output logic [1:0]                 status,
    output logic [CNT_W-1:0]           stack_depth,
    output logic [31:0]                top_value,
    output logic                       top_valid
);

    // Entries below the top live in memory; the top lives in top_reg.
    logic [DATA_WIDTH-1:0]  mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0]  rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;

    core_state_t            state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [DATA_WIDTH-1:0]  top_reg, top_next;
    kind_t                  kind_reg, kind_next;
    status_t                stat_reg, stat_next;

    logic                   rsp_valid_reg, rsp_valid_next;
    status_t                rsp_status_reg;
    logic [CNT_W-1:0]       rsp_depth_reg;
    logic [DATA_WIDTH-1:0]  rsp_top_reg;
    logic                   rsp_load;

    logic [CNT_W-1:0]       cnt_m1;
    logic [CNT_W-1:0]       cnt_m2;
    logic [CNT_W-1:0]       cnt_m3;
    logic                   div_start;
    logic                   div_done;
    logic [DATA_WIDTH-1:0]  div_rem;

    assign cnt_m1 = count_reg - CNT_W'(1);
    assign cnt_m2 = count_reg - CNT_W'(2);
    assign cnt_m3 = count_reg - CNT_W'(3);

    psc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rd_data_reg),
        .divisor   (top_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= top_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        top_next   = top_reg;
        kind_next  = kind_reg;
        stat_next  = stat_reg;
        mem_we     = 1'b0;
        mem_waddr  = cnt_m1[ADDR_W-1:0];
        mem_re     = 1'b0;
        mem_raddr  = cnt_m2[ADDR_W-1:0];
        div_start  = 1'b0;
        q_pop      = 1'b0;
        rsp_load   = 1'b0;
        unique case (state_reg)
            CORE_IDLE:
            begin
                if (q_in.valid)
                begin
                    q_pop      = 1'b1;
                    kind_next  = q_in.op.kind;
                    stat_next  = STAT_DONE;
                    state_next = CORE_RESP;
                    unique case (q_in.op.kind)
                        KIND_PUSH:
                        begin
                            if (count_reg == CNT_W'(STACK_DEPTH))
                            begin
                                stat_next = STAT_OVERFLOW;
                            end
                            else
                            begin
                                mem_we     = (count_reg != '0);
                                top_next   = q_in.op.value;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_NOP:
                        begin
                        end
                        default:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                stat_next = STAT_UNDERFLOW;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = CORE_READ;
                            end
                        end
                    endcase
                end
            end
            CORE_READ:
            begin
                state_next = CORE_RESP;
                unique case (kind_reg)
                    KIND_ADD:
                    begin
                        top_next   = rd_data_reg + top_reg;
                        count_next = cnt_m1;
                    end
                    KIND_SUB:
                    begin
                        top_next   = rd_data_reg - top_reg;
                        count_next = cnt_m1;
                    end
                    KIND_MUL:
                    begin
                        top_next   = rd_data_reg * top_reg;
                        count_next = cnt_m1;
                    end
                    default:
                    begin
                        if (top_reg == '0)
                        begin
                            stat_next  = STAT_DIV_ZERO;
                            count_next = cnt_m2;
                            if (count_reg > CNT_W'(2))
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = cnt_m3[ADDR_W-1:0];
                                state_next = CORE_DROP;
                            end
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = CORE_DIV;
                        end
                    end
                endcase
            end
            CORE_DIV:
            begin
                if (div_done)
                begin
                    top_next   = div_rem;
                    count_next = cnt_m1;
                    state_next = CORE_RESP;
                end
            end
            CORE_DROP:
            begin
                top_next   = rd_data_reg;
                state_next = CORE_RESP;
            end
            CORE_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = CORE_IDLE;
                end
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = rsp_load || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CORE_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        kind_reg <= kind_next;
        stat_reg <= stat_next;
        if (rsp_load)
        begin
            rsp_status_reg <= stat_reg;
            rsp_depth_reg  <= count_reg;
            rsp_top_reg    <= (count_reg != '0) ? top_reg : '0;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign stack_depth = rsp_depth_reg;
    assign top_value   = rsp_top_reg[31:0];
    assign top_valid   = (rsp_depth_reg != '0);

endmodule

`default_nettype wire

@@ design/postfix_stack_calculator.sv @@
// Top level of the postfix stack calculator: front end, queue and core.
// Each command word gives one response word. Push, ignored codes and
// operators skipped for underflow go straight from idle to the response
// state in the core; add, subtract and multiply first read the second
// entry from stack memory, then apply the ALU; a remainder by zero does
// the same read, and a further one when the entry below must be fetched
// as the new top; remainder waits on the remainder unit, which resolves
// one quotient bit per cycle. A two-word queue sits in front of the core,
// so commands are taken while the core is busy, and a response register
// lets the core finish while the response waits. Stack depth is 64 words
// of 32 bits; unwritten stack words are never read.
`timescale 1ns / 1ps
`default_nettype none

module postfix_stack_calculator
    import psc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_stall,
    input  wire logic [2:0]            cmd,
    input  wire logic signed [31:0]    operand_value,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output logic [1:0]                 status,
    output logic [6:0]                 stack_depth,
    output logic signed [31:0]         top_value,
    output logic                       top_valid
);

    qlink_t q_link;
    logic   q_pop;

    psc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .operand_value (operand_value),
        .q_out         (q_link),
        .q_pop         (q_pop)
    );

    psc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_in        (q_link),
        .q_pop       (q_pop),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .stack_depth (stack_depth),
        .top_value   (top_value),
        .top_valid   (top_valid)
    );

endmodule

`default_nettype wire

@@ design/psc_checker.sv @@
// Checker on the calculator's response port, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module psc_checker
    import psc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         rsp_valid,
    input  wire logic         rsp_stall,
    input  wire logic [1:0]   status,
    input  wire logic [6:0]   stack_depth,
    input  wire logic [31:0]  top_value,
    input  wire logic         top_valid
);

    `PSC_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(stack_depth) && $stable(top_value), "response word changed while stalled")
    `PSC_ASSERT_IMP(a_top_valid, rsp_valid, top_valid == (stack_depth != 7'd0), "top_valid disagrees with depth")
    `PSC_ASSERT_IMP(a_depth_max, rsp_valid, stack_depth <= 7'(STACK_DEPTH), "depth beyond stack size")
    `PSC_ASSERT_IMP(a_empty_top, rsp_valid && !top_valid, top_value == 32'd0, "empty stack with nonzero top")
    `PSC_ASSERT_IMP(a_ovf_full, rsp_valid && (status == STAT_OVERFLOW), stack_depth == 7'(STACK_DEPTH), "overflow reported on a stack that is not full")

endmodule

bind postfix_stack_calculator psc_checker u_psc_checker (.*);

`default_nettype wire

@@ tb/sv/postfix_stack_calculator_test.sv @@
// Testbench for the postfix stack calculator: directed table, random words, self-checking.
`timescale 1ns / 1ps

module postfix_stack_calculator_test;
    import psc_pkg::*;

    localparam logic [2:0]  CMD_SPARE_A   = 3'd5;
    localparam logic [2:0]  CMD_SPARE_B   = 3'd6;
    localparam logic [2:0]  CMD_SPARE_C   = 3'd7;
    localparam logic [31:0] VAL_MIN       = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_ALL_ONES  = 32'hFFFF_FFFF;
    localparam int          CYCLE_LIMIT   = 800_000;
    localparam int          DRAIN_CYCLES  = 64;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          ROW_COUNT     = 24;

    typedef struct packed {
        status_t     st;
        logic [6:0]  depth;
        logic [31:0] top;
        logic        tvalid;
    } stack_report_t;

    typedef struct packed {
        logic [2:0]    op;
        logic [31:0]   value;
        logic          typed;
        stack_report_t want;
    } directed_row_t;

    localparam stack_report_t NO_REPORT = '0;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    logic [2:0]         cmd = CMD_PUSH;
    logic signed [31:0] operand_value = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [1:0]         status;
    logic [6:0]         stack_depth;
    logic signed [31:0] top_value;
    logic               top_valid;

    logic [31:0]   calc_stack [STACK_DEPTH];
    int            calc_depth = 0;
    stack_report_t pending_reports [$];
    int            word_count = 0;
    int            fills_left = 2;
    int            fail_count = 0;
    int            cycle_count = 0;
    int            rsp_hold_request = 0;
    bit            quiet = 1'b0;

    directed_row_t directed_rows [ROW_COUNT] = '{
        '{CMD_ADD,     32'd0,        1'b1, '{STAT_UNDERFLOW, 7'd0, 32'd0, 1'b0}},
        '{CMD_REM,     32'd0,        1'b1, '{STAT_UNDERFLOW, 7'd0, 32'd0, 1'b0}},
        '{CMD_PUSH,    VAL_MAX,      1'b1, '{STAT_DONE, 7'd1, VAL_MAX, 1'b1}},
        '{CMD_SUB,     32'd0,        1'b1, '{STAT_UNDERFLOW, 7'd1, VAL_MAX, 1'b1}},
        '{CMD_PUSH,    32'd1,        1'b0, NO_REPORT},
        '{CMD_ADD,     VAL_ALL_ONES, 1'b0, NO_REPORT},
        '{CMD_PUSH,    VAL_ALL_ONES, 1'b0, NO_REPORT},
        '{CMD_REM,     32'd0,        1'b0, NO_REPORT},
        '{CMD_PUSH,    32'd5,        1'b0, NO_REPORT},
        '{CMD_PUSH,    32'd0,        1'b1, '{STAT_DONE, 7'd3, 32'd0, 1'b1}},
        '{CMD_REM,     32'd0,        1'b1, '{STAT_DIV_ZERO, 7'd1, 32'd0, 1'b1}},
        '{CMD_PUSH,    VAL_MIN,      1'b0, NO_REPORT},
        '{CMD_PUSH,    32'd3,        1'b0, NO_REPORT},
        '{CMD_MUL,     32'd0,        1'b0, NO_REPORT},
        '{CMD_PUSH,    32'hFFFF_FFF9, 1'b0, NO_REPORT},
        '{CMD_PUSH,    32'd3,        1'b0, NO_REPORT},
        '{CMD_REM,     32'd0,        1'b0, NO_REPORT},
        '{CMD_SUB,     32'd0,        1'b0, NO_REPORT},
        '{CMD_PUSH,    32'hFFFF_FFFD, 1'b0, NO_REPORT},
        '{CMD_REM,     32'd0,        1'b0, NO_REPORT},
        '{CMD_SPARE_A, VAL_ALL_ONES, 1'b0, NO_REPORT},
        '{CMD_SPARE_B, VAL_MIN,      1'b0, NO_REPORT},
        '{CMD_SPARE_C, VAL_MAX,      1'b0, NO_REPORT},
        '{CMD_MUL,     32'd0,        1'b0, NO_REPORT}
    };

    postfix_stack_calculator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .operand_value (operand_value),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .stack_depth   (stack_depth),
        .top_value     (top_value),
        .top_valid     (top_valid)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Applies one command word to the shadow stack and returns the expected report.
    function automatic stack_report_t apply_word(logic [2:0] c, logic [31:0] v);
        stack_report_t rep;
        logic [31:0]   a;
        logic [31:0]   b;
        logic [31:0]   r;
        logic [31:0]   ua;
        logic [31:0]   ub;
        rep.st = STAT_DONE;
        r = '0;
        if (c == CMD_PUSH)
        begin
            if (calc_depth == STACK_DEPTH)
                rep.st = STAT_OVERFLOW;
            else
            begin
                calc_stack[calc_depth] = v;
                calc_depth++;
            end
        end
        else if (c <= CMD_REM)
        begin
            if (calc_depth < 2)
                rep.st = STAT_UNDERFLOW;
            else
            begin
                b = calc_stack[calc_depth - 1];
                a = calc_stack[calc_depth - 2];
                calc_depth -= 2;
                case (c)
                    CMD_ADD: r = a + b;
                    CMD_SUB: r = a - b;
                    CMD_MUL: r = a * b;
                    default:
                    begin
                        if (b == '0)
                            rep.st = STAT_DIV_ZERO;
                        else
                        begin
                            // truncating remainder on magnitudes, sign of dividend
                            ua = a[31] ? -a : a;
                            ub = b[31] ? -b : b;
                            r = ua % ub;
                            if (a[31])
                                r = -r;
                        end
                    end
                endcase
                if (rep.st == STAT_DONE)
                begin
                    calc_stack[calc_depth] = r;
                    calc_depth++;
                end
            end
        end
        rep.depth = 7'(calc_depth);
        rep.tvalid = (calc_depth > 0);
        rep.top = (calc_depth > 0) ? calc_stack[calc_depth - 1] : '0;
        return rep;
    endfunction

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else if (pick < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'd1;
            2: return VAL_ALL_ONES;
            3: return VAL_MIN;
            4: return VAL_MAX;
            5, 6: return 32'($urandom_range(0, 40)) - 32'd20;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] rand_operator();
        case ($urandom_range(0, 3))
            0: return CMD_ADD;
            1: return CMD_SUB;
            2: return CMD_MUL;
            default: return CMD_REM;
        endcase
    endfunction

    // Offers one word, waits for the handshake, then records the expected report.
    task automatic send_word(logic [2:0] c, logic [31:0] v, logic typed,
                             stack_report_t want);
        int            gap;
        stack_report_t rep;
        gap = idle_len();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        operand_value <= v;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        rep = apply_word(c, v);
        pending_reports.push_back(typed ? want : rep);
        if (c <= CMD_REM)
            word_count++;
    endtask

    task automatic run_random(int target);
        int pick;
        int k;
        while (word_count < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4 && fills_left > 0)
            begin
                fills_left--;
                while (calc_depth < STACK_DEPTH)
                    send_word(CMD_PUSH, rand_operand(), 1'b0, NO_REPORT);
                repeat ($urandom_range(1, 3))
                    send_word(CMD_PUSH, rand_operand(), 1'b0, NO_REPORT);
                while (calc_depth >= 2)
                    send_word(rand_operator(), $urandom, 1'b0, NO_REPORT);
                send_word(rand_operator(), $urandom, 1'b0, NO_REPORT);
            end
            else if (pick < 60)
            begin
                k = $urandom_range(1, 4);
                repeat (k)
                    send_word(CMD_PUSH, rand_operand(), 1'b0, NO_REPORT);
                repeat (k + $urandom_range(0, 1))
                    send_word(rand_operator(), $urandom, 1'b0, NO_REPORT);
            end
            else if (pick < 75)
            begin
                repeat ($urandom_range(3, 12))
                    send_word(CMD_PUSH, rand_operand(), 1'b0, NO_REPORT);
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(1, 6))
                    send_word(rand_operator(), $urandom, 1'b0, NO_REPORT);
            end
            else
                send_word(3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C)), $urandom,
                          1'b0, NO_REPORT);
        end
    endtask

    // Response side: random stalls, long hold-off on request, in-order checking.
    initial
    begin
        int            stall_left;
        stack_report_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("unexpected response word: status %0d depth %0d", status,
                           stack_depth);
                    fail_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (status != want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        fail_count++;
                    end
                    if (stack_depth != want.depth)
                    begin
                        $error("stack_depth: expected %0d, got %0d", want.depth,
                               stack_depth);
                        fail_count++;
                    end
                    if (top_value != want.top)
                    begin
                        $error("top_value: expected %h, got %h", want.top, top_value);
                        fail_count++;
                    end
                    if (top_valid != want.tvalid)
                    begin
                        $error("top_valid: expected %0d, got %0d", want.tvalid,
                               top_valid);
                        fail_count++;
                    end
                end
            end
            if (rsp_hold_request > 0)
            begin
                stall_left = rsp_hold_request;
                rsp_hold_request = 0;
            end
            else if (stall_left == 0)
                stall_left = idle_len();
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < ROW_COUNT; i++)
            send_word(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].want);

        run_random(200);

        // let the pipeline empty before the back-pressure stretch
        cmd_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        rsp_hold_request = HOLD_CYCLES;
        run_random(word_count + 20);

        quiet = 1'b1;
        run_random(word_count + 60);
        quiet = 1'b0;

        run_random(600);

        cmd_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
